// ----- hw/rtl/tsc_pkg.sv -----
// Package: shared types and constants of the TCP server connection block.
package tsc_pkg;

   localparam logic [31:0] FIXED_ISN = 32'hAA55AA55;
   localparam logic [15:0] WINDOW = 16'd1400;
   localparam logic [2:0] HDR_PLAIN = 3'd5;
   localparam logic [2:0] HDR_SYNACK = 3'd6;

   localparam logic [1:0] REG_LPORT_A = 2'd0;
   localparam logic [1:0] REG_LPORT_B = 2'd1;
   localparam logic [1:0] REG_MAX_A = 2'd2;
   localparam logic [1:0] REG_MAX_B = 2'd3;

   typedef enum logic [3:0] {
      CN_CLOSED = 4'd0,
      CN_LISTEN = 4'd1,
      CN_SYNRX = 4'd2,
      CN_ESTAB = 4'd3,
      CN_FINW1 = 4'd4,
      CN_FINW2 = 4'd5,
      CN_TIMEW = 4'd6,
      CN_CLOSEW = 4'd7,
      CN_LASTACK = 4'd8
   } cn_state_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DRAIN,
      BK_DECIDE,
      BK_EXEC
   } bk_state_type;

   typedef struct packed {
      logic [31:0] src_ip;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic flag_syn;
      logic flag_ack;
      logic flag_rst;
      logic flag_fin;
      logic [31:0] rx_seq;
      logic [31:0] rx_ack;
      logic [15:0] ip_total_length;
      logic [3:0] header_words;
      logic app_accepts;
   } req_type;

   typedef struct packed {
      logic [1:0] slot;
      logic reply_syn;
      logic reply_ackflag;
      logic reply_rst;
      logic [31:0] reply_seq;
      logic [31:0] reply_acknum;
      logic [31:0] reply_dst_ip;
      logic [15:0] reply_dst_port;
      logic [15:0] reply_src_port;
      logic [2:0] reply_hdr_words;
      logic [5:0] payload_offset;
      logic [15:0] payload_size;
   } rsp_type;

   typedef struct packed {
      req_type req;
      logic [5:0] poff;
      logic [15:0] psize;
   } item_type;

   typedef struct packed {
      logic [15:0] lport_a;
      logic [15:0] lport_b;
      logic [2:0] lmax_a;
      logic [2:0] lmax_b;
   } cfg_type;

   typedef struct packed {
      logic [31:0] ip;
      logic [15:0] port;
      logic [31:0] seq;
      logic [31:0] ack;
   } rec_type;

endpackage

// ----- hw/rtl/tcp_server_connection_fsm.sv -----
// Top level: TCP server connection state machine with listener registers.
//  channel | direction | ports
//  req     | in        | req_valid, req_ready, req_data
//  rsp     | out       | rsp_valid, rsp_ready, rsp_data
//  csr     | in        | csr_we, csr_index, csr_wdata
// One transaction walks the back-end states scan, drain, decide and exec, skipping exec
// when no slot is found; the scan reads one slot per cycle.
// A two-entry queue sits between front end and back end.
// Synchronous active-high reset closes all slots and clears listener registers.
// A full reply register stalls only the final state update.
module tcp_server_connection_fsm #(
   parameter int SLOTS = 4,
   parameter int LISTENERS = 2,
   parameter int IP_HEADER_BYTES = 20
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  tsc_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output tsc_pkg::rsp_type rsp_data,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_wdata
);
   import tsc_pkg::*;

   cfg_type cfg_ff;
   logic q_valid, q_ready;
   item_type q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_LPORT_A: cfg_ff.lport_a <= csr_wdata;
            REG_LPORT_B: if (LISTENERS > 1) cfg_ff.lport_b <= csr_wdata;
            REG_MAX_A: cfg_ff.lmax_a <= csr_wdata[2:0];
            REG_MAX_B: if (LISTENERS > 1) cfg_ff.lmax_b <= csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   tsc_front #(.IP_HEADER_BYTES(IP_HEADER_BYTES)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
   );

   tsc_back #(.SLOTS(SLOTS), .LISTENERS(LISTENERS)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );
endmodule

// ----- hw/rtl/tsc_front.sv -----
// Front end: accepts segment headers, computes payload offset and size, queues them.
module tsc_front #(
   parameter int IP_HEADER_BYTES = 20
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  tsc_pkg::req_type req_data,
   output logic q_valid,
   input  logic q_ready,
   output tsc_pkg::item_type q_item
);
   import tsc_pkg::*;

   item_type fifo_ff [2];
   logic wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   item_type cls;
   logic [16:0] used;
   logic push, pop;

   always_comb begin
      cls.req = req_data;
      cls.poff = {req_data.header_words, 2'b00};
      used = 17'(IP_HEADER_BYTES) + 17'(cls.poff);
      cls.psize = ({1'b0, req_data.ip_total_length} > used) ?
                  16'({1'b0, req_data.ip_total_length} - used) : 16'd0;
   end

   assign req_ready = (cnt_ff != 2'd2);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = fifo_ff[rp_ff];
   assign push = req_valid && req_ready;
   assign pop = q_valid && q_ready;

   always_comb begin
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      cnt_in = 2'(cnt_ff + 2'(push) - 2'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wp_ff] <= cls;
      end
   end
endmodule

// ----- hw/rtl/tsc_back.sv -----
// Back end: slot scan, listener selection, connection state update and reply register.
module tsc_back #(
   parameter int SLOTS = 4,
   parameter int LISTENERS = 2
) (
   input  logic clock,
   input  logic reset,
   input  tsc_pkg::cfg_type cfg,
   input  logic q_valid,
   output logic q_ready,
   input  tsc_pkg::item_type q_item,
   output logic rsp_valid,
   input  logic rsp_ready,
   output tsc_pkg::rsp_type rsp_data
);
   import tsc_pkg::*;

   localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW0 = $clog2(SLOTS + 1);
   localparam int KW = (CW0 > 3) ? CW0 : 3;

   bk_state_type st_ff, st_in;
   item_type item_ff, item_in;
   logic [SW-1:0] cnt_ff, cnt_in, s_ff, s_in, p_idx_ff, rd_idx;
   logic p_vld_ff;
   logic fm_ff, fm_in, ff_ff, ff_in;
   logic [SW-1:0] m_idx_ff, m_idx_in, f_idx_ff, f_idx_in;
   logic [KW-1:0] ca_ff, ca_in, cb_ff, cb_in;
   logic claim_ff, claim_in, sel_ff, sel_in;

   rec_type rec_mem [SLOTS];
   logic [3:0] cst_ff [SLOTS];
   logic own_ff [SLOTS];
   rec_type rec_q_ff;
   logic [3:0] cst_q_ff;
   logic own_q_ff;

   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic ok_a, ok_b, live;
   logic wr_en, fire;
   cn_state_type cur, nst;
   rec_type rec_w;
   logic own_w, own_cur, emit, clr;
   logic [31:0] e_seq, e_ack, seq0, ack0, ip0;
   logic [15:0] port0;
   logic e_syn, e_ack_f, e_rst;
   logic [2:0] e_hdr;
   logic [5:0] e_poff;
   logic [15:0] e_psize;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   always_comb begin
      ok_a = (cfg.lmax_a != 3'd0) && (cfg.lport_a == item_ff.req.dst_port) &&
             (ca_ff < KW'(cfg.lmax_a));
      ok_b = (LISTENERS > 1) && (cfg.lmax_b != 3'd0) &&
             (cfg.lport_b == item_ff.req.dst_port) && (cb_ff < KW'(cfg.lmax_b));
   end

   // per-slot scan evaluation
   always_comb begin
      live = (cst_q_ff != CN_CLOSED);
      fm_in = fm_ff;
      m_idx_in = m_idx_ff;
      ff_in = ff_ff;
      f_idx_in = f_idx_ff;
      ca_in = ca_ff;
      cb_in = cb_ff;
      if (p_vld_ff) begin
         if (live && !fm_ff && rec_q_ff.port == item_ff.req.src_port &&
             rec_q_ff.ip == item_ff.req.src_ip) begin
            fm_in = 1'b1;
            m_idx_in = p_idx_ff;
         end
         if (!live && !ff_ff) begin
            ff_in = 1'b1;
            f_idx_in = p_idx_ff;
         end
         if (live && !own_q_ff) ca_in = KW'(ca_ff + KW'(1));
         if (live && own_q_ff) cb_in = KW'(cb_ff + KW'(1));
      end
   end

   // connection state step on the chosen slot
   always_comb begin
      cur = claim_ff ? CN_LISTEN : cn_state_type'(cst_q_ff);
      seq0 = claim_ff ? 32'd0 : rec_q_ff.seq;
      ack0 = claim_ff ? 32'd0 : rec_q_ff.ack;
      ip0 = claim_ff ? item_ff.req.src_ip : rec_q_ff.ip;
      port0 = claim_ff ? item_ff.req.src_port : rec_q_ff.port;
      own_cur = claim_ff ? sel_ff : own_q_ff;
      nst = cur;
      emit = 1'b0;
      clr = 1'b0;
      e_syn = 1'b0;
      e_ack_f = 1'b1;
      e_rst = 1'b0;
      e_seq = seq0;
      e_ack = ack0;
      e_hdr = HDR_PLAIN;
      e_poff = 6'd0;
      e_psize = 16'd0;
      case (cur)
         CN_CLOSED: begin
            if (item_ff.req.flag_fin) begin
               nst = CN_CLOSEW;
               emit = 1'b1;
            end
         end
         CN_LISTEN: begin
            if (item_ff.req.flag_syn) begin
               emit = 1'b1;
               e_seq = FIXED_ISN;
               e_ack = 32'(item_ff.req.rx_seq + 32'd1);
               e_hdr = HDR_SYNACK;
               if (item_ff.req.app_accepts) begin
                  nst = CN_SYNRX;
                  e_syn = 1'b1;
               end else begin
                  nst = CN_CLOSED;
                  e_ack_f = 1'b0;
                  e_rst = 1'b1;
                  clr = 1'b1;
               end
            end
         end
         CN_SYNRX: begin
            if (item_ff.req.flag_ack && !item_ff.req.flag_syn) nst = CN_ESTAB;
            else if (item_ff.req.flag_rst) nst = CN_LISTEN;
         end
         CN_ESTAB: begin
            emit = 1'b1;
            if (item_ff.req.flag_fin) begin
               nst = CN_CLOSEW;
            end else begin
               e_seq = item_ff.req.rx_ack;
               e_ack = 32'(item_ff.req.rx_seq + 32'(item_ff.psize));
               e_poff = item_ff.poff;
               e_psize = item_ff.psize;
            end
         end
         CN_FINW1: begin
            if (item_ff.req.flag_ack) begin
               if (!item_ff.req.flag_fin) begin
                  nst = CN_FINW2;
               end else begin
                  nst = CN_TIMEW;
                  emit = 1'b1;
               end
            end else if (item_ff.req.flag_fin) begin
               nst = CN_TIMEW;
               emit = 1'b1;
               e_seq = FIXED_ISN;
               e_ack = 32'(item_ff.req.rx_seq + 32'd1);
            end
         end
         CN_FINW2: begin
            if (item_ff.req.flag_fin) begin
               nst = CN_TIMEW;
               emit = 1'b1;
            end
         end
         CN_TIMEW: nst = CN_CLOSED;
         CN_CLOSEW: begin
            nst = CN_CLOSED;
            emit = 1'b1;
            e_ack_f = 1'b0;
            e_rst = 1'b1;
            e_ack = 32'd0;
         end
         CN_LASTACK: begin
            nst = CN_CLOSED;
            emit = 1'b1;
         end
         default: nst = CN_LISTEN;
      endcase
      rec_w.ip = ip0;
      rec_w.port = port0;
      rec_w.seq = clr ? 32'd0 : (emit ? e_seq : seq0);
      rec_w.ack = clr ? 32'd0 : (emit ? e_ack : ack0);
      own_w = clr ? 1'b0 : own_cur;
   end

   always_comb begin
      st_in = st_ff;
      item_in = item_ff;
      cnt_in = cnt_ff;
      s_in = s_ff;
      claim_in = claim_ff;
      sel_in = sel_ff;
      q_ready = 1'b0;
      rd_idx = s_ff;
      wr_en = 1'b0;
      fire = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      case (st_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_ready = 1'b1;
               item_in = q_item;
               cnt_in = '0;
               st_in = BK_SCAN;
            end
         end
         BK_SCAN: begin
            rd_idx = cnt_ff;
            if (cnt_ff == SW'(SLOTS - 1)) st_in = BK_DRAIN;
            else cnt_in = SW'(cnt_ff + SW'(1));
         end
         BK_DRAIN: st_in = BK_DECIDE;
         BK_DECIDE: begin
            claim_in = 1'b0;
            sel_in = !ok_a;
            st_in = BK_EXEC;
            if (fm_ff) begin
               s_in = m_idx_ff;
            end else if (ff_ff && (ok_a || ok_b)) begin
               s_in = f_idx_ff;
               claim_in = 1'b1;
            end else begin
               st_in = BK_IDLE;
            end
            rd_idx = s_in;
         end
         BK_EXEC: begin
            if (!rsp_valid_ff || rsp_ready) begin
               fire = 1'b1;
               wr_en = 1'b1;
               st_in = BK_IDLE;
               if (emit) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.slot = 2'(s_ff);
                  rsp_in.reply_syn = e_syn;
                  rsp_in.reply_ackflag = e_ack_f;
                  rsp_in.reply_rst = e_rst;
                  rsp_in.reply_seq = e_seq;
                  rsp_in.reply_acknum = e_ack;
                  rsp_in.reply_dst_ip = ip0;
                  rsp_in.reply_dst_port = port0;
                  rsp_in.reply_src_port = (LISTENERS > 1 && own_cur) ?
                                          cfg.lport_b : cfg.lport_a;
                  rsp_in.reply_hdr_words = e_hdr;
                  rsp_in.payload_offset = e_poff;
                  rsp_in.payload_size = e_psize;
               end
            end
         end
         default: st_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= BK_IDLE;
         p_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            cst_ff[i] <= CN_CLOSED;
            own_ff[i] <= 1'b0;
         end
      end else begin
         st_ff <= st_in;
         p_vld_ff <= (st_ff == BK_SCAN);
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            cst_ff[s_ff] <= nst;
            own_ff[s_ff] <= own_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      cnt_ff <= cnt_in;
      s_ff <= s_in;
      claim_ff <= claim_in;
      sel_ff <= sel_in;
      p_idx_ff <= rd_idx;
      rsp_ff <= rsp_in;
      rec_q_ff <= rec_mem[rd_idx];
      cst_q_ff <= cst_ff[rd_idx];
      own_q_ff <= own_ff[rd_idx];
      if (st_ff == BK_IDLE) begin
         fm_ff <= 1'b0;
         ff_ff <= 1'b0;
         m_idx_ff <= '0;
         f_idx_ff <= '0;
         ca_ff <= '0;
         cb_ff <= '0;
      end else begin
         fm_ff <= fm_in;
         ff_ff <= ff_in;
         m_idx_ff <= m_idx_in;
         f_idx_ff <= f_idx_in;
         ca_ff <= ca_in;
         cb_ff <= cb_in;
      end
      if (wr_en) begin
         rec_mem[s_ff] <= rec_w;
      end
   end
endmodule

// ----- dv/tcp_server_connection_fsm_checker.sv -----
// Checker: predicts TCP connection replies and compares them with the block.
module tcp_server_connection_fsm_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  tsc_pkg::req_type req_data,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  tsc_pkg::rsp_type rsp_data,
   input  logic csr_we,
   input  logic [1:0] csr_index,
   input  logic [15:0] csr_wdata,
   output int fail_count,
   output int pending
);
   import tsc_pkg::*;

   localparam int NSLOT = 4;
   localparam int IP_HEADER_BYTES = 20;

   logic [15:0] lport [2];
   logic [2:0] lmax [2];
   logic [3:0] cstate [NSLOT];
   logic [31:0] raddr [NSLOT];
   logic [15:0] rport [NSLOT];
   logic ownr [NSLOT];
   logic [31:0] lseq [NSLOT];
   logic [31:0] lack [NSLOT];
   rsp_type reply_q [$];

   assign pending = reply_q.size();

   function automatic int live_slots(int l);
      int c;
      c = 0;
      for (int i = 0; i < NSLOT; i++)
         if (cstate[i] != CN_CLOSED && ownr[i] == l) c++;
      return c;
   endfunction

   task automatic push_reply(int s, logic syn, logic ack, logic rst, logic [31:0] seq,
                             logic [31:0] an, logic [2:0] hdr, logic [5:0] poff,
                             logic [15:0] psize);
      rsp_type r;
      lseq[s] = seq;
      lack[s] = an;
      r.slot = s[1:0];
      r.reply_syn = syn;
      r.reply_ackflag = ack;
      r.reply_rst = rst;
      r.reply_seq = seq;
      r.reply_acknum = an;
      r.reply_dst_ip = raddr[s];
      r.reply_dst_port = rport[s];
      r.reply_src_port = lport[ownr[s]];
      r.reply_hdr_words = hdr;
      r.payload_offset = poff;
      r.payload_size = psize;
      reply_q.push_back(r);
   endtask

   task automatic predict_segment(req_type q);
      int s, f, l;
      logic [31:0] seq, an, off, used, size;
      s = -1;
      f = -1;
      for (int i = NSLOT - 1; i >= 0; i--) begin
         if (cstate[i] != CN_CLOSED && rport[i] == q.src_port && raddr[i] == q.src_ip) s = i;
         if (cstate[i] == CN_CLOSED) f = i;
      end
      if (s < 0) begin
         if (f < 0) return;
         l = 2;
         for (int k = 1; k >= 0; k--)
            if (lmax[k] != 0 && lport[k] == q.dst_port && live_slots(k) < lmax[k]) l = k;
         if (l == 2) return;
         s = f;
         cstate[s] = CN_LISTEN;
         raddr[s] = q.src_ip;
         rport[s] = q.src_port;
         ownr[s] = l[0];
         lseq[s] = '0;
         lack[s] = '0;
      end
      seq = lseq[s];
      an = lack[s];
      case (cstate[s])
         CN_CLOSED: if (q.flag_fin) begin
            cstate[s] = CN_CLOSEW;
            push_reply(s, 0, 1, 0, seq, an, HDR_PLAIN, 0, 0);
         end
         CN_LISTEN: if (q.flag_syn) begin
            if (q.app_accepts) begin
               cstate[s] = CN_SYNRX;
               push_reply(s, 1, 1, 0, FIXED_ISN, q.rx_seq + 1, HDR_SYNACK, 0, 0);
            end else begin
               push_reply(s, 0, 0, 1, FIXED_ISN, q.rx_seq + 1, HDR_SYNACK, 0, 0);
               cstate[s] = CN_CLOSED;
               ownr[s] = 1'b0;
               lseq[s] = '0;
               lack[s] = '0;
            end
         end
         CN_SYNRX: begin
            if (q.flag_ack && !q.flag_syn) cstate[s] = CN_ESTAB;
            else if (q.flag_rst) cstate[s] = CN_LISTEN;
         end
         CN_ESTAB: if (q.flag_fin) begin
            cstate[s] = CN_CLOSEW;
            push_reply(s, 0, 1, 0, seq, an, HDR_PLAIN, 0, 0);
         end else begin
            off = 4 * q.header_words;
            used = IP_HEADER_BYTES + off;
            size = q.ip_total_length > used ? q.ip_total_length - used : 0;
            push_reply(s, 0, 1, 0, q.rx_ack, q.rx_seq + size, HDR_PLAIN, off[5:0],
                       size[15:0]);
         end
         CN_FINW1: begin
            if (q.flag_ack) begin
               if (!q.flag_fin) cstate[s] = CN_FINW2;
               else begin
                  cstate[s] = CN_TIMEW;
                  push_reply(s, 0, 1, 0, seq, an, HDR_PLAIN, 0, 0);
               end
            end else if (q.flag_fin) begin
               cstate[s] = CN_TIMEW;
               push_reply(s, 0, 1, 0, FIXED_ISN, q.rx_seq + 1, HDR_PLAIN, 0, 0);
            end
         end
         CN_FINW2: if (q.flag_fin) begin
            cstate[s] = CN_TIMEW;
            push_reply(s, 0, 1, 0, seq, an, HDR_PLAIN, 0, 0);
         end
         CN_TIMEW: cstate[s] = CN_CLOSED;
         CN_CLOSEW: begin
            cstate[s] = CN_CLOSED;
            push_reply(s, 0, 0, 1, seq, 0, HDR_PLAIN, 0, 0);
         end
         CN_LASTACK: begin
            cstate[s] = CN_CLOSED;
            push_reply(s, 0, 1, 0, seq, an, HDR_PLAIN, 0, 0);
         end
         default: cstate[s] = CN_LISTEN;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type exp_r;
      if (reset) begin
         fail_count <= 0;
         reply_q.delete();
         for (int i = 0; i < 2; i++) begin
            lport[i] = '0;
            lmax[i] = '0;
         end
         for (int i = 0; i < NSLOT; i++) begin
            cstate[i] = CN_CLOSED;
            raddr[i] = '0;
            rport[i] = '0;
            ownr[i] = 1'b0;
            lseq[i] = '0;
            lack[i] = '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_LPORT_A: lport[0] = csr_wdata;
               REG_LPORT_B: lport[1] = csr_wdata;
               REG_MAX_A: lmax[0] = csr_wdata[2:0];
               REG_MAX_B: lmax[1] = csr_wdata[2:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (reply_q.size() == 0) begin
               $display("%0t: unexpected reply, expected none, actual %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = reply_q.pop_front();
               if (rsp_data !== exp_r) begin
                  $display("%0t: reply mismatch, expected %h, actual %h", $time, exp_r,
                           rsp_data);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_valid && req_ready) predict_segment(req_data);
      end
   end
endmodule

// ----- dv/tcp_server_connection_fsm_tb.sv -----
// Testbench top: drives segments and listener settings, gives the verdict.
module tcp_server_connection_fsm_tb;
   import tsc_pkg::*;

   localparam int REQ_W = $bits(req_type);

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_type rsp_data;
   logic csr_we = 0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;
   int fail_count;
   int pending;
   int cycles = 0;
   bit hold_off = 0;
   bit stim_done = 0;
   logic [31:0] peer_ip [4];
   logic [15:0] peer_port [4];
   logic [15:0] port_a, port_b;

   tcp_server_connection_fsm dut (.*);

   tcp_server_connection_fsm_checker chk (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("tcp_server_connection_fsm_tb: FAIL");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (hold_off) rsp_ready <= 0;
      else if (cycles % 64 < 16) rsp_ready <= 1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   task automatic send_segment(req_type q);
      req_valid <= 1;
      req_data <= q;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if ($urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 0;
   endtask

   task automatic drain_idle();
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic configure(logic [15:0] pa, logic [15:0] pb, logic [2:0] ma, logic [2:0] mb);
      drain_idle();
      port_a = pa;
      port_b = pb;
      write_reg(REG_LPORT_A, pa);
      write_reg(REG_LPORT_B, pb);
      write_reg(REG_MAX_A, {13'd0, ma});
      write_reg(REG_MAX_B, {13'd0, mb});
   endtask

   function automatic req_type make_seg(int p, bit syn, bit ack, bit rst, bit fin, bit acc);
      req_type q;
      q.src_ip = peer_ip[p];
      q.src_port = peer_port[p];
      q.dst_port = $urandom_range(0, 1) ? port_a : port_b;
      if ($urandom_range(0, 15) == 0) q.dst_port = 16'($urandom);
      q.flag_syn = syn;
      q.flag_ack = ack;
      q.flag_rst = rst;
      q.flag_fin = fin;
      q.rx_seq = $urandom;
      q.rx_ack = $urandom;
      q.ip_total_length = $urandom_range(0, 3) == 0 ? 16'($urandom) :
                          16'($urandom_range(0, 200));
      q.header_words = 4'($urandom);
      q.app_accepts = acc;
      return q;
   endfunction

   task automatic random_phase(int n);
      req_type q;
      int p;
      for (int i = 0; i < n; i++) begin
         p = $urandom_range(0, 3);
         case ($urandom_range(0, 9))
            0: q = make_seg(p, 1, 0, 0, 0, $urandom_range(0, 4) != 0);
            1: q = make_seg(p, 0, 1, 0, 0, 1);
            2, 3, 4: q = make_seg(p, 0, 1, 0, 0, 1);
            5: q = make_seg(p, 0, 1, 0, 1, 1);
            6: q = make_seg(p, 0, 0, 1, 0, 1);
            default: begin
               q = make_seg(p, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                            1'($urandom));
               if ($urandom_range(0, 3) == 0) q = REQ_W'({$urandom, $urandom, $urandom,
                                                          $urandom, $urandom, $urandom});
            end
         endcase
         send_segment(q);
      end
   endtask

   initial begin
      req_type q;
      for (int i = 0; i < 4; i++) begin
         peer_ip[i] = $urandom;
         peer_port[i] = 16'($urandom);
      end
      peer_ip[0] = '1;
      peer_port[0] = '1;
      peer_ip[1] = '0;
      peer_port[1] = '0;
      repeat (2) @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // no listener enabled: nothing happens
      port_a = 16'd80;
      port_b = 16'd80;
      send_segment(make_seg(0, 1, 0, 0, 0, 1));
      configure(16'hFFFF, 16'h0000, 3'd7, 3'd4);
      // handshake, data, close; reject; fin paths
      q = make_seg(0, 1, 0, 0, 0, 1); q.dst_port = 16'hFFFF; send_segment(q);
      q = make_seg(0, 0, 1, 0, 0, 1); send_segment(q);
      q = make_seg(0, 0, 1, 0, 0, 1); q.ip_total_length = 16'hFFFF; q.header_words = 4'hF;
      send_segment(q);
      q = make_seg(0, 0, 1, 0, 0, 1); q.ip_total_length = 16'd0; send_segment(q);
      q = make_seg(0, 0, 1, 0, 1, 1); send_segment(q);
      q = make_seg(0, 0, 0, 0, 0, 1); send_segment(q);
      q = make_seg(1, 1, 0, 0, 0, 0); q.dst_port = 16'h0000; send_segment(q);
      q = make_seg(1, 0, 0, 0, 0, 1); q.dst_port = 16'h0000; send_segment(q);
      q = make_seg(1, 1, 0, 0, 0, 1); q.dst_port = 16'h0000; send_segment(q);
      q = make_seg(1, 1, 1, 1, 0, 1); send_segment(q);
      q = make_seg(1, 1, 0, 0, 0, 1); send_segment(q);
      configure(16'd443, 16'd443, 3'd1, 3'd1);
      for (int i = 0; i < 4; i++) begin
         q = make_seg(i, 1, 0, 0, 0, 1); q.dst_port = 16'd443; send_segment(q);
      end

      // long receiver stall while segments keep coming
      configure(16'd80, 16'd8080, 3'd4, 3'd4);
      hold_off = 1;
      fork
         begin
            repeat (300) @(negedge clock);
            hold_off = 0;
         end
         random_phase(60);
      join

      random_phase(300);
      configure(16'd22, 16'd22, 3'd2, 3'd1);
      random_phase(250);
      configure(16'($urandom), 16'($urandom), 3'd3, 3'd0);
      random_phase(200);
      configure(16'd0, 16'hFFFF, 3'd0, 3'd2);
      random_phase(250);
      drain_idle();
      if (fail_count == 0) begin
         $display("tcp_server_connection_fsm_tb: PASS");
      end else begin
         $display("tcp_server_connection_fsm_tb: FAIL");
      end
      $finish;
   end
endmodule
